// ===== design/drs_pkg.sv =====
`timescale 1ns / 1ps
package drs_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int REC_W   = DAY_W + MONTH_W + YEAR_W;

   typedef enum logic [2:0] {
      S_LOAD,
      S_DECIDE,
      S_PRIME,
      S_FIRST,
      S_STEP,
      S_TAIL,
      S_READ,
      S_SHOW
   } state_type;

   typedef enum logic [1:0] {
      WR_LOAD,
      WR_STEP,
      WR_TAIL
   } wr_sel_type;

   typedef struct packed {
      logic       load;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       rd_en;
      logic       j_clear;
      logic       j_inc;
      logic       carry_load;
      logic       carry_swap;
      logic       pass_clear;
      logic       pass_inc;
      logic       set_clear;
   } dp_cmd_type;

   typedef struct packed {
      logic n_ge2;
      logic j_lt_n;
      logic pass_done;
      logic last;
   } dp_status_type;

endpackage

// ===== design/date_record_sorter.sv =====
`timescale 1ns / 1ps
// Collects date records one beat per cycle into a store of MAX_RECORDS entries; the beat
// with req_is_last closes the set, and records past capacity are dropped and reported on
// rsp_overflow. The set is then sorted in place, stable and ascending by year, month and
// day, by bubble passes over a store that takes one read and one write per cycle, so a
// set of n records takes n-1 passes, after a decision step. With compare enable clear,
// or fewer than two records, the sort is skipped. Records then leave one at a time, each
// read from the store and then offered as an output beat. No input is taken while a set
// is sorted or drained. The configuration write is always ready.
module date_record_sorter
   import drs_pkg::*;
#(
   parameter int MAX_RECORDS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [DAY_W-1:0]   req_day,
   input  logic [MONTH_W-1:0] req_month,
   input  logic [YEAR_W-1:0]  req_year,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [DAY_W-1:0]   rsp_out_day,
   output logic [MONTH_W-1:0] rsp_out_month,
   output logic [YEAR_W-1:0]  rsp_out_year,
   output logic               rsp_out_last,
   output logic               rsp_overflow,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   drs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_is_last  (req_is_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_last (rsp_out_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .status       (status),
      .cmd          (cmd)
   );

   drs_datapath #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_day       (req_day),
      .req_month     (req_month),
      .req_year      (req_year),
      .rsp_out_day   (rsp_out_day),
      .rsp_out_month (rsp_out_month),
      .rsp_out_year  (rsp_out_year),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

// ===== design/drs_datapath.sv =====
`timescale 1ns / 1ps
module drs_datapath
   import drs_pkg::*;
#(
   parameter int MAX_RECORDS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic [DAY_W-1:0]     req_day,
   input  logic [MONTH_W-1:0]   req_month,
   input  logic [YEAR_W-1:0]    req_year,
   output logic [DAY_W-1:0]     rsp_out_day,
   output logic [MONTH_W-1:0]   rsp_out_month,
   output logic [YEAR_W-1:0]    rsp_out_year,
   output logic                 rsp_overflow
);

   localparam int CNT_W = $clog2(MAX_RECORDS + 1);
   localparam int IDX_W = $clog2(MAX_RECORDS);

   logic [REC_W-1:0] mem [MAX_RECORDS];

   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] pass_ff, pass_in;
   logic [REC_W-1:0] carry_ff, carry_in;
   logic [REC_W-1:0] rd_ff;

   logic [REC_W-1:0] req_rec;
   logic             room;
   logic             rd_less;
   logic             wr_go;
   logic [IDX_W-1:0] wr_addr;
   logic [REC_W-1:0] wr_data;
   logic [CNT_W-1:0] j_m2;
   logic [CNT_W-1:0] cnt_m1;
   logic [CNT_W-1:0] cnt_m2;

   assign req_rec = {req_year, req_month, req_day};
   assign room    = count_ff < CNT_W'(MAX_RECORDS);
   assign rd_less = rd_ff < carry_ff;
   assign j_m2    = j_ff - CNT_W'(2);
   assign cnt_m1  = count_ff - CNT_W'(1);
   assign cnt_m2  = count_ff - CNT_W'(2);

   always_comb begin
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = req_rec;
      wr_go   = cmd.wr_en;
      case (cmd.wr_sel)
         WR_LOAD: begin
            wr_addr = count_ff[IDX_W-1:0];
            wr_data = req_rec;
            wr_go   = cmd.wr_en && room;
         end
         WR_STEP: begin
            wr_addr = j_m2[IDX_W-1:0];
            wr_data = rd_less ? rd_ff : carry_ff;
         end
         WR_TAIL: begin
            wr_addr = cnt_m1[IDX_W-1:0];
            wr_data = carry_ff;
         end
         default: begin
            wr_go = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.set_clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (cmd.load) begin
         if (room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_comb begin
      j_in = j_ff;
      if (cmd.j_clear) begin
         j_in = '0;
      end else if (cmd.j_inc) begin
         j_in = j_ff + CNT_W'(1);
      end
      pass_in = pass_ff;
      if (cmd.pass_clear) begin
         pass_in = '0;
      end else if (cmd.pass_inc) begin
         pass_in = pass_ff + CNT_W'(1);
      end
      carry_in = carry_ff;
      if (cmd.carry_load) begin
         carry_in = rd_ff;
      end else if (cmd.carry_swap) begin
         carry_in = rd_less ? carry_ff : rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         j_ff       <= '0;
         pass_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         j_ff       <= j_in;
         pass_ff    <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

   always_ff @(posedge clock) begin
      if (wr_go) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[j_ff[IDX_W-1:0]];
      end
   end

   assign status.n_ge2     = count_ff >= CNT_W'(2);
   assign status.j_lt_n    = j_ff < count_ff;
   assign status.pass_done = pass_ff == cnt_m2;
   assign status.last      = j_ff == count_ff;

   assign rsp_out_day   = rd_ff[DAY_W-1:0];
   assign rsp_out_month = rd_ff[DAY_W+MONTH_W-1:DAY_W];
   assign rsp_out_year  = rd_ff[REC_W-1:DAY_W+MONTH_W];
   assign rsp_overflow  = dropped_ff;

endmodule

// ===== design/drs_ctrl.sv =====
`timescale 1ns / 1ps
module drs_ctrl
   import drs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_is_last,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_out_last,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_data,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      enable_ff, enable_in;

   assign csr_ready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      if (csr_valid) begin
         enable_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         enable_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         enable_ff <= enable_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_valid && req_is_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (enable_ff && status.n_ge2) begin
               state_in = S_PRIME;
            end else begin
               state_in = S_READ;
            end
         end
         S_PRIME: state_in = S_FIRST;
         S_FIRST: state_in = S_STEP;
         S_STEP: begin
            if (!status.j_lt_n) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (status.pass_done) begin
               state_in = S_READ;
            end else begin
               state_in = S_PRIME;
            end
         end
         S_READ: state_in = S_SHOW;
         S_SHOW: begin
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = S_LOAD;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.wr_sel   = WR_LOAD;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      rsp_out_last = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load  = 1'b1;
               cmd.wr_en = 1'b1;
               if (req_is_last) begin
                  cmd.j_clear    = 1'b1;
                  cmd.pass_clear = 1'b1;
               end
            end
         end
         S_DECIDE: begin
         end
         S_PRIME: begin
            cmd.rd_en = 1'b1;
            cmd.j_inc = 1'b1;
         end
         S_FIRST: begin
            cmd.carry_load = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.j_inc      = 1'b1;
         end
         S_STEP: begin
            cmd.wr_en      = 1'b1;
            cmd.wr_sel     = WR_STEP;
            cmd.carry_swap = 1'b1;
            if (status.j_lt_n) begin
               cmd.rd_en = 1'b1;
               cmd.j_inc = 1'b1;
            end
         end
         S_TAIL: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_TAIL;
            cmd.j_clear = 1'b1;
            if (!status.pass_done) begin
               cmd.pass_inc = 1'b1;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            cmd.j_inc = 1'b1;
         end
         S_SHOW: begin
            rsp_valid    = 1'b1;
            rsp_out_last = status.last;
            if (rsp_ready && status.last) begin
               cmd.set_clear = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== bench/date_record_sorter_tb.sv =====
`timescale 1ns / 1ps
module date_record_sorter_tb
   import drs_pkg::*;
();

   localparam int SET_CAPACITY  = 32;
   localparam int SETTLE_CYCLES = 20;
   localparam int TAIL_CYCLES   = 50;
   localparam int STALL_LIMIT   = 5000;
   localparam int PHASE_ITEMS   = 60;
   localparam int DIR_N         = 20;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic               last;
      logic               overflow;
   } date_result_type;

   typedef struct packed {
      date_type        rec;
      logic            last;
      logic            typed;
      date_result_type want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [DAY_W-1:0]   req_day = '0;
   logic [MONTH_W-1:0] req_month = '0;
   logic [YEAR_W-1:0]  req_year = '0;
   logic               req_is_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [DAY_W-1:0]   rsp_out_day;
   logic [MONTH_W-1:0] rsp_out_month;
   logic [YEAR_W-1:0]  rsp_out_year;
   logic               rsp_out_last;
   logic               rsp_overflow;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_data = 1'b0;

   date_type        held_dates [SET_CAPACITY];
   int unsigned     held_count = 0;
   bit              lost_record = 1'b0;
   bit              sort_by_date = 1'b1;
   date_result_type sorted_batch [$];
   date_result_type pending_dates [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int records_checked = 0;
   int sets_closed = 0;
   int overflow_sets = 0;
   int stall_cycles = 0;

   stim_row_type dir_rows [DIR_N] = '{
      '{'{14'd16383, 4'd15, 5'd31}, 1'b1, 1'b1, '{5'd31, 4'd15, 14'd16383, 1'b1, 1'b0}},
      '{'{14'd0, 4'd0, 5'd0}, 1'b1, 1'b1, '{5'd0, 4'd0, 14'd0, 1'b1, 1'b0}},
      '{'{14'd2000, 4'd3, 5'd5}, 1'b0, 1'b0, '0},
      '{'{14'd2000, 4'd3, 5'd4}, 1'b0, 1'b0, '0},
      '{'{14'd2000, 4'd2, 5'd5}, 1'b0, 1'b0, '0},
      '{'{14'd1999, 4'd1, 5'd1}, 1'b0, 1'b0, '0},
      '{'{14'd2000, 4'd3, 5'd5}, 1'b1, 1'b0, '0},
      '{'{14'd0, 4'd0, 5'd31}, 1'b0, 1'b0, '0},
      '{'{14'd0, 4'd15, 5'd0}, 1'b1, 1'b0, '0},
      '{'{14'd1, 4'd0, 5'd0}, 1'b0, 1'b0, '0},
      '{'{14'd0, 4'd15, 5'd31}, 1'b1, 1'b0, '0},
      '{'{14'd16383, 4'd1, 5'd1}, 1'b0, 1'b0, '0},
      '{'{14'd8192, 4'd2, 5'd2}, 1'b0, 1'b0, '0},
      '{'{14'd4096, 4'd3, 5'd3}, 1'b0, 1'b0, '0},
      '{'{14'd1, 4'd4, 5'd4}, 1'b0, 1'b0, '0},
      '{'{14'd0, 4'd14, 5'd30}, 1'b1, 1'b0, '0},
      '{'{14'd10922, 4'd9, 5'd17}, 1'b0, 1'b0, '0},
      '{'{14'd5461, 4'd6, 5'd10}, 1'b0, 1'b0, '0},
      '{'{14'd5461, 4'd10, 5'd21}, 1'b1, 1'b0, '0},
      '{'{14'd5461, 4'd10, 5'd21}, 1'b1, 1'b1, '{5'd21, 4'd10, 14'd5461, 1'b1, 1'b0}}
   };

   date_record_sorter #(
      .MAX_RECORDS(SET_CAPACITY)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_day       (req_day),
      .req_month     (req_month),
      .req_year      (req_year),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_day   (rsp_out_day),
      .rsp_out_month (rsp_out_month),
      .rsp_out_year  (rsp_out_year),
      .rsp_out_last  (rsp_out_last),
      .rsp_overflow  (rsp_overflow),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 20) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
      end
   endtask

   // store one date; on the closing beat, bubble-sort the set if date compare is on and emit it
   task automatic collate_date(input date_type d, input bit last);
      date_type        swap_tmp;
      date_result_type r;
      sorted_batch.delete();
      if (held_count < SET_CAPACITY) begin
         held_dates[held_count] = d;
         held_count++;
      end else begin
         lost_record = 1'b1;
      end
      if (!last) return;
      for (int i = 0; i + 1 < held_count; i++) begin
         for (int j = 0; j + 1 < held_count; j++) begin
            if (sort_by_date && held_dates[j+1] < held_dates[j]) begin
               swap_tmp        = held_dates[j];
               held_dates[j]   = held_dates[j+1];
               held_dates[j+1] = swap_tmp;
            end
         end
      end
      for (int k = 0; k < held_count; k++) begin
         r.day      = held_dates[k].day;
         r.month    = held_dates[k].month;
         r.year     = held_dates[k].year;
         r.last     = (k + 1 == held_count);
         r.overflow = lost_record;
         sorted_batch.push_back(r);
      end
      sets_closed++;
      if (lost_record) overflow_sets++;
      held_count  = 0;
      lost_record = 1'b0;
   endtask

   task automatic send_date(input date_type d, input bit last, input bit typed,
                            input date_result_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_day     <= d.day;
      req_month   <= d.month;
      req_year    <= d.year;
      req_is_last <= last;
      do @(posedge clock); while (!req_ready);
      collate_date(d, last);
      if (typed) begin
         pending_dates.push_back(want);
      end else begin
         foreach (sorted_batch[k]) pending_dates.push_back(sorted_batch[k]);
      end
      @(negedge clock);
   endtask

   task automatic write_compare_enable(input bit en);
      while (pending_dates.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= en;
      do @(posedge clock); while (!csr_ready);
      sort_by_date = en;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_sets(input bit en, input int s_pct, input int r_pct, input int target);
      int       sent;
      int       len;
      bit       narrow;
      date_type d;
      write_compare_enable(en);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      while (sent < target) begin
         if (sent == 0) begin
            len = SET_CAPACITY + 1 + $urandom_range(0, 2);
         end else if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(SET_CAPACITY - 2, SET_CAPACITY + 4);
         end else begin
            len = $urandom_range(1, 8);
         end
         narrow = $urandom_range(0, 1);
         for (int k = 0; k < len; k++) begin
            if (narrow) begin
               d.year  = YEAR_W'(2000 + $urandom_range(0, 3));
               d.month = MONTH_W'($urandom_range(1, 3));
               d.day   = DAY_W'($urandom_range(1, 4));
            end else begin
               d = REC_W'($urandom);
            end
            send_date(d, k == len - 1, 1'b0, '0);
         end
         sent += len;
      end
      req_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      date_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         records_checked++;
         if (pending_dates.size() == 0) begin
            report_mismatch($sformatf("unexpected record %0d-%0d-%0d",
                                      rsp_out_year, rsp_out_month, rsp_out_day));
         end else begin
            want = pending_dates.pop_front();
            check_field("day", int'(rsp_out_day), int'(want.day));
            check_field("month", int'(rsp_out_month), int'(want.month));
            check_field("year", int'(rsp_out_year), int'(want.year));
            check_field("last", int'(rsp_out_last), int'(want.last));
            check_field("overflow", int'(rsp_overflow), int'(want.overflow));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 31;
      recv_idle_pct = 55;
      write_compare_enable(1'b1);
      foreach (dir_rows[i]) begin
         send_date(dir_rows[i].rec, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
      end
      req_valid <= 1'b0;
      run_sets(1'b0, 31, 55, PHASE_ITEMS);
      run_sets(1'b1, 31, 55, PHASE_ITEMS);
      run_sets(1'b1, 55, 31, PHASE_ITEMS);
      run_sets(1'b0, 55, 31, PHASE_ITEMS);
      run_sets(1'b1, 0, 0, PHASE_ITEMS);
      while (pending_dates.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Sorted %0d sets (%0d past capacity), %0d records checked, %0d mismatches.",
               sets_closed, overflow_sets, records_checked, mismatch_count);
      $display("Date compare was toggled on and off under three handshake pressure modes.");
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/drs_pkg.sv
design/drs_datapath.sv
design/drs_ctrl.sv
design/date_record_sorter.sv
bench/date_record_sorter_tb.sv
